// ===== design/stt_pkg.sv =====
package stt_pkg;

  // Scanner modes; the unused codes behave like idle.
  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_SLASH   = 3'd1,
    M_COMMENT = 3'd2,
    M_STRING  = 3'd3,
    M_NUMBER  = 3'd4,
    M_IDENT   = 3'd5
  } mode_t;

  // Token kinds.
  localparam logic [4:0] K_EOF       = 5'd0;
  localparam logic [4:0] K_PLUS      = 5'd1;
  localparam logic [4:0] K_MINUS     = 5'd2;
  localparam logic [4:0] K_EQUAL     = 5'd3;
  localparam logic [4:0] K_ASTERISK  = 5'd4;
  localparam logic [4:0] K_SLASH     = 5'd5;
  localparam logic [4:0] K_BACKSLASH = 5'd6;
  localparam logic [4:0] K_POWER     = 5'd7;
  localparam logic [4:0] K_BANG      = 5'd8;
  localparam logic [4:0] K_OPEN      = 5'd9;
  localparam logic [4:0] K_CLOSE     = 5'd10;
  localparam logic [4:0] K_STRING    = 5'd11;
  localparam logic [4:0] K_NUMBER    = 5'd12;
  localparam logic [4:0] K_BOOLEAN   = 5'd13;
  localparam logic [4:0] K_KEYWORD   = 5'd14;
  localparam logic [4:0] K_IDENT     = 5'd15;
  localparam logic [4:0] K_UNKNOWN   = 5'd16;

  // Keyword codes.
  localparam logic [1:0] KW_NONE  = 2'd0;
  localparam logic [1:0] KW_TRUE  = 2'd1;
  localparam logic [1:0] KW_FALSE = 2'd2;
  localparam logic [1:0] KW_IF    = 2'd3;

  // Characters with a special meaning to the scanner.
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_BACKTICK  = 8'h60;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  localparam int REC_POS_W = 16;

  // One token record as delivered on the output channel.
  typedef struct packed {
    logic [4:0]           token_kind;
    logic [1:0]           keyword_code;
    logic [REC_POS_W-1:0] start_pos;
    logic [REC_POS_W-1:0] end_pos;
    logic                 unterminated;
    logic                 pos_overflow;
    logic                 last_of_run;
  } rec_t;

  // Keyword spelling: index 0 is "true", 1 is "false", 2 is "if".
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] ch;
    ch = 8'h00;
    case ({k, i})
      5'b00_000: ch = 8'h74;
      5'b00_001: ch = 8'h72;
      5'b00_010: ch = 8'h75;
      5'b00_011: ch = 8'h65;
      5'b01_000: ch = 8'h66;
      5'b01_001: ch = 8'h61;
      5'b01_010: ch = 8'h6C;
      5'b01_011: ch = 8'h73;
      5'b01_100: ch = 8'h65;
      5'b10_000: ch = 8'h69;
      5'b10_001: ch = 8'h66;
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] n;
    case (k)
      2'd0:    n = 3'd4;
      2'd1:    n = 3'd5;
      2'd2:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Kind of a one-byte operator but slash, or end of file code for any other byte.
  function automatic logic [4:0] op_kind(input logic [7:0] c);
    logic [4:0] kd;
    case (c)
      8'h2B:   kd = K_PLUS;
      8'h2D:   kd = K_MINUS;
      8'h3D:   kd = K_EQUAL;
      8'h2A:   kd = K_ASTERISK;
      8'h5C:   kd = K_BACKSLASH;
      8'h5E:   kd = K_POWER;
      8'h21:   kd = K_BANG;
      8'h28:   kd = K_OPEN;
      8'h29:   kd = K_CLOSE;
      default: kd = K_EOF;
    endcase
    return kd;
  endfunction

endpackage

// ===== design/stt_in_if.sv =====
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_marker;

  modport source (output valid, output character, output end_marker, input ready);
  modport sink (input valid, input character, input end_marker, output ready);
endinterface

// ===== design/stt_out_if.sv =====
interface stt_out_if;
  logic                           valid;
  logic                           ready;
  logic [4:0]                     token_kind;
  logic [1:0]                     keyword_code;
  logic [stt_pkg::REC_POS_W-1:0]  start_pos;
  logic [stt_pkg::REC_POS_W-1:0]  end_pos;
  logic                           unterminated;
  logic                           pos_overflow;
  logic                           last_of_run;

  modport source (output valid, output token_kind, output keyword_code, output start_pos,
                  output end_pos, output unterminated, output pos_overflow,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input keyword_code, input start_pos,
                input end_pos, input unterminated, input pos_overflow,
                input last_of_run, output ready);
endinterface

// ===== design/source_text_tokenizer.sv =====
// Source text tokenizer.
// The text channel carries one source byte per item, or an end marker item
// that closes the input. The tokens channel carries token records: kind,
// keyword code, start and end positions and flags. An item yields zero, one
// or two records; last_of_run marks the final record of an item, and the end
// marker always yields at least the eof record.
// An accepted item is scanned in the same cycle against the scanner state and
// its records are written to a four-entry record queue; the records are
// registered there and offered on the tokens channel from its head, in order.
// One item is accepted per cycle while the queue holds at most two records,
// so text that yields one record per byte or fewer streams at one byte per
// cycle; items that yield two records are drained at one record per cycle.
// When the receiver stalls, the queue fills and text.ready falls until room
// for two records is free again; no record is lost or reordered.
// Reset empties the queue, returns the scanner to idle and clears the byte
// position and the overflow flag; the block is ready in the next cycle.
// Positions count up to 2**POS_BITS-1 and then hold with pos_overflow set.
module source_text_tokenizer #(
  parameter int POS_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  stt_in_if.sink    text,
  stt_out_if.source tokens
);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Scanner state.
  stt_pkg::mode_t      mode, mode_next;
  logic [POS_BITS-1:0] byte_position, byte_position_next;
  logic [POS_BITS-1:0] token_start, token_start_next;
  logic [7:0]          open_quote, open_quote_next;
  logic [2:0]          kw_cand, kw_cand_next;
  logic [2:0]          ident_len, ident_len_next;
  logic                overflow_seen, overflow_seen_next;

  logic                accept;
  logic                can_take;
  logic [1:0]          push_count;
  logic [1:0]          rec_count;
  stt_pkg::rec_t       rec0, rec1;

  logic [7:0]          c;
  logic                is_digit, is_alpha, is_space, is_quote;
  logic [POS_BITS-1:0] idx, prev;
  logic                at_max;
  logic [2:0]          take_cand;
  logic [2:0]          take_len;
  logic [2:0]          init_cand;
  logic [2:0]          init_len;
  logic [1:0]          cur_code;
  logic [4:0]          cur_ident_kind;
  logic [4:0]          op;
  logic                flag_ovf;
  logic                fl_valid, sec_valid, do_begin;
  stt_pkg::rec_t       fl_rec, sec_rec;

  function automatic stt_pkg::rec_t mk_rec(input logic [4:0] kind, input logic [1:0] kw,
                                           input logic [POS_BITS-1:0] s,
                                           input logic [POS_BITS-1:0] e,
                                           input logic u, input logic o);
    stt_pkg::rec_t r;
    r.token_kind   = kind;
    r.keyword_code = kw;
    r.start_pos    = stt_pkg::REC_POS_W'(s);
    r.end_pos      = stt_pkg::REC_POS_W'(e);
    r.unterminated = u;
    r.pos_overflow = o;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // Drop keyword candidates that no longer match after one more letter.
  function automatic logic [2:0] cand_take(input logic [2:0] cand, input logic [2:0] len,
                                           input logic [7:0] ch);
    logic [2:0] nc;
    nc = cand;
    for (int k = 0; k < 3; k++) begin
      if (cand[k] && (len >= stt_pkg::kw_len(2'(k)) || stt_pkg::kw_char(2'(k), len) != ch)) begin
        nc[k] = 1'b0;
      end
    end
    return nc;
  endfunction

  function automatic logic [1:0] cand_code(input logic [2:0] cand, input logic [2:0] len);
    logic [1:0] code;
    code = stt_pkg::KW_NONE;
    for (int k = 0; k < 3; k++) begin
      if (cand[k] && len == stt_pkg::kw_len(2'(k))) begin
        code = 2'(k + 1);
      end
    end
    return code;
  endfunction

  // Character classes and position helpers.
  assign c        = text.character;
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = (c == stt_pkg::CH_UNDERSCORE) || ((c >= 8'h41) && (c <= 8'h5A)) ||
                    ((c >= 8'h61) && (c <= 8'h7A));
  assign is_space = (c == stt_pkg::CH_SPACE) || (c == stt_pkg::CH_NEWLINE) ||
                    (c == stt_pkg::CH_TAB);
  assign is_quote = (c == stt_pkg::CH_DQUOTE) || (c == stt_pkg::CH_BACKTICK) ||
                    (c == stt_pkg::CH_SQUOTE);
  assign idx      = byte_position;
  assign prev     = (byte_position == '0) ? '0 : byte_position - 1'b1;
  assign at_max   = (byte_position == POS_MAX);
  assign op       = stt_pkg::op_kind(c);

  assign take_cand = cand_take(kw_cand, ident_len, c);
  assign take_len  = (ident_len < 3'd7) ? ident_len + 3'd1 : ident_len;
  assign init_cand = cand_take(3'b111, 3'd0, c);
  assign init_len  = 3'd1;

  assign cur_code       = cand_code(kw_cand, ident_len);
  assign cur_ident_kind = (cur_code == stt_pkg::KW_TRUE || cur_code == stt_pkg::KW_FALSE) ?
                          stt_pkg::K_BOOLEAN :
                          (cur_code == stt_pkg::KW_IF) ? stt_pkg::K_KEYWORD : stt_pkg::K_IDENT;

  // Scanner: pending-token flush, then the token the current byte opens.
  always_comb begin
    mode_next          = mode;
    byte_position_next = byte_position;
    token_start_next   = token_start;
    open_quote_next    = open_quote;
    kw_cand_next       = kw_cand;
    ident_len_next     = ident_len;
    overflow_seen_next = overflow_seen;
    fl_valid           = 1'b0;
    sec_valid          = 1'b0;
    do_begin           = 1'b0;
    flag_ovf           = overflow_seen;
    fl_rec             = mk_rec(stt_pkg::K_EOF, stt_pkg::KW_NONE, '0, '0, 1'b0, 1'b0);
    sec_rec            = fl_rec;

    if (text.end_marker) begin
      // End of input: flush the open token, then the eof record.
      case (mode)
        stt_pkg::M_SLASH: begin
          fl_valid = 1'b1;
          fl_rec = mk_rec(stt_pkg::K_SLASH, stt_pkg::KW_NONE, token_start, token_start,
                          1'b0, flag_ovf);
        end
        stt_pkg::M_STRING: begin
          fl_valid = 1'b1;
          fl_rec = mk_rec(stt_pkg::K_STRING, stt_pkg::KW_NONE, token_start, byte_position,
                          1'b1, flag_ovf);
        end
        stt_pkg::M_NUMBER: begin
          fl_valid = 1'b1;
          fl_rec = mk_rec(stt_pkg::K_NUMBER, stt_pkg::KW_NONE, token_start, prev,
                          1'b0, flag_ovf);
        end
        stt_pkg::M_IDENT: begin
          fl_valid = 1'b1;
          fl_rec = mk_rec(cur_ident_kind, cur_code, token_start, prev, 1'b0, flag_ovf);
        end
        default: begin
          fl_valid = 1'b0;
        end
      endcase
      sec_valid = 1'b1;
      sec_rec = mk_rec(stt_pkg::K_EOF, stt_pkg::KW_NONE, byte_position, byte_position,
                       1'b0, flag_ovf);
      mode_next          = stt_pkg::M_IDLE;
      byte_position_next = '0;
      overflow_seen_next = 1'b0;
    end else begin
      // Advance the position, saturating at the top.
      if (at_max) begin
        overflow_seen_next = 1'b1;
      end else begin
        byte_position_next = byte_position + 1'b1;
      end
      flag_ovf = overflow_seen_next;

      case (mode)
        stt_pkg::M_SLASH: begin
          if (c == stt_pkg::CH_SLASH) begin
            mode_next = stt_pkg::M_COMMENT;
          end else begin
            fl_valid = 1'b1;
            fl_rec = mk_rec(stt_pkg::K_SLASH, stt_pkg::KW_NONE, token_start, token_start,
                            1'b0, flag_ovf);
            do_begin = 1'b1;
          end
        end
        stt_pkg::M_COMMENT: begin
          if (c == stt_pkg::CH_NEWLINE) begin
            mode_next = stt_pkg::M_IDLE;
          end
        end
        stt_pkg::M_STRING: begin
          if (c == open_quote) begin
            fl_valid = 1'b1;
            fl_rec = mk_rec(stt_pkg::K_STRING, stt_pkg::KW_NONE, token_start, idx,
                            1'b0, flag_ovf);
            mode_next = stt_pkg::M_IDLE;
          end
        end
        stt_pkg::M_NUMBER: begin
          if (!is_digit) begin
            fl_valid = 1'b1;
            fl_rec = mk_rec(stt_pkg::K_NUMBER, stt_pkg::KW_NONE, token_start, prev,
                            1'b0, flag_ovf);
            do_begin = 1'b1;
          end
        end
        stt_pkg::M_IDENT: begin
          if (is_alpha || is_digit) begin
            kw_cand_next   = take_cand;
            ident_len_next = take_len;
          end else begin
            fl_valid = 1'b1;
            fl_rec = mk_rec(cur_ident_kind, cur_code, token_start, prev, 1'b0, flag_ovf);
            do_begin = 1'b1;
          end
        end
        default: begin
          do_begin = 1'b1;
        end
      endcase

      // Start of a new token at this byte.
      if (do_begin) begin
        mode_next = stt_pkg::M_IDLE;
        if (is_space) begin
          mode_next = stt_pkg::M_IDLE;
        end else if (c == stt_pkg::CH_SLASH) begin
          mode_next        = stt_pkg::M_SLASH;
          token_start_next = idx;
        end else if (is_quote) begin
          mode_next        = stt_pkg::M_STRING;
          open_quote_next  = c;
          token_start_next = at_max ? POS_MAX : idx + 1'b1;
        end else if (op != stt_pkg::K_EOF) begin
          sec_valid = 1'b1;
          sec_rec = mk_rec(op, stt_pkg::KW_NONE, idx, idx, 1'b0, flag_ovf);
        end else if (is_digit) begin
          mode_next        = stt_pkg::M_NUMBER;
          token_start_next = idx;
        end else if (is_alpha) begin
          mode_next        = stt_pkg::M_IDENT;
          token_start_next = idx;
          kw_cand_next     = init_cand;
          ident_len_next   = init_len;
        end else begin
          sec_valid = 1'b1;
          sec_rec = mk_rec(stt_pkg::K_UNKNOWN, stt_pkg::KW_NONE, idx, idx, 1'b0, flag_ovf);
        end
      end
    end
  end

  // Pack the records in order and mark the final one.
  always_comb begin
    rec_count = {1'b0, fl_valid} + {1'b0, sec_valid};
    rec0 = fl_valid ? fl_rec : sec_rec;
    rec1 = sec_rec;
    rec0.last_of_run = (rec_count == 2'd1);
    rec1.last_of_run = 1'b1;
  end

  assign text.ready = can_take;
  assign accept     = text.valid & can_take;
  assign push_count = accept ? rec_count : 2'd0;

  // Scanner state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= stt_pkg::M_IDLE;
      byte_position <= '0;
      token_start   <= '0;
      open_quote    <= 8'h00;
      kw_cand       <= 3'b111;
      ident_len     <= 3'd0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      byte_position <= byte_position_next;
      token_start   <= token_start_next;
      open_quote    <= open_quote_next;
      kw_cand       <= kw_cand_next;
      ident_len     <= ident_len_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  stt_rec_fifo u_rec_fifo (
    .clk        (clk),
    .rst        (rst),
    .rec0       (rec0),
    .rec1       (rec1),
    .push_count (push_count),
    .can_take   (can_take),
    .tokens     (tokens)
  );

endmodule

// ===== design/stt_rec_fifo.sv =====
module stt_rec_fifo (
  input  logic            clk,
  input  logic            rst,
  input  stt_pkg::rec_t   rec0,
  input  stt_pkg::rec_t   rec1,
  input  logic [1:0]      push_count,
  output logic            can_take,
  stt_out_if.source       tokens
);

  stt_pkg::rec_t entries [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] count;
  logic       pop;

  assign pop = tokens.valid & tokens.ready;

  // Room for the two records one item can produce.
  assign can_take = (count <= 3'd2);

  // Head entry drives the output channel.
  assign tokens.valid        = (count != 3'd0);
  assign tokens.token_kind   = entries[rd_ptr].token_kind;
  assign tokens.keyword_code = entries[rd_ptr].keyword_code;
  assign tokens.start_pos    = entries[rd_ptr].start_pos;
  assign tokens.end_pos      = entries[rd_ptr].end_pos;
  assign tokens.unterminated = entries[rd_ptr].unterminated;
  assign tokens.pos_overflow = entries[rd_ptr].pos_overflow;
  assign tokens.last_of_run  = entries[rd_ptr].last_of_run;

  // Record storage, written in order at the tail.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= rec0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= rec1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 2'd0;
      wr_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push_count} - {2'b00, pop};
    end
  end

endmodule

// ===== tb/tb_source_text_tokenizer.sv =====
module tb_source_text_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam int ID_LEN_MAX = 7;
  localparam int RANDOM_ITEMS_PER_PHASE = 340;
  localparam int DRAIN_CYCLES = 20;

  // Predicts the token records of the tokenizer and checks the records that come out.
  class token_scoreboard;
    stt_pkg::rec_t expected_tokens[$];
    stt_pkg::rec_t item_records[$];
    stt_pkg::mode_t scan_state;
    logic [POS_BITS-1:0] pos;
    logic [POS_BITS-1:0] tok_start;
    logic [7:0] quote;
    logic [2:0] cand;
    logic [2:0] id_len;
    bit ovf;
    int mismatches;
    int records_checked;
    string kw_spell[3] = '{"true", "false", "if"};
    logic [1:0] kw_codes[3] = '{stt_pkg::KW_TRUE, stt_pkg::KW_FALSE, stt_pkg::KW_IF};

    function new();
      scan_state = stt_pkg::M_IDLE;
      pos = '0;
      tok_start = '0;
      quote = '0;
      cand = 3'b111;
      id_len = '0;
      ovf = 1'b0;
      mismatches = 0;
      records_checked = 0;
    endfunction

    // Queues one record of the current item; the overflow flag is taken as it stands now.
    function void add_record(logic [4:0] kind, logic [1:0] kw, logic [POS_BITS-1:0] s,
                             logic [POS_BITS-1:0] e, logic unterm);
      stt_pkg::rec_t r;
      r.token_kind = kind;
      r.keyword_code = kw;
      r.start_pos = stt_pkg::REC_POS_W'(s);
      r.end_pos = stt_pkg::REC_POS_W'(e);
      r.unterminated = unterm;
      r.pos_overflow = ovf;
      r.last_of_run = 1'b0;
      item_records.push_back(r);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(logic [7:0] c);
      return c == stt_pkg::CH_UNDERSCORE || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    // Narrows the keyword candidates by one more identifier character.
    function void take_ident_char(logic [7:0] c);
      for (int k = 0; k < 3; k++) begin
        if (cand[k]) begin
          if (id_len >= kw_spell[k].len() || kw_spell[k][id_len] != c) cand[k] = 1'b0;
        end
      end
      if (id_len < ID_LEN_MAX) id_len++;
    endfunction

    function void finish_ident(logic [POS_BITS-1:0] last);
      logic [1:0] code;
      logic [4:0] kind;
      code = stt_pkg::KW_NONE;
      for (int k = 0; k < 3; k++) begin
        if (cand[k] && id_len == kw_spell[k].len()) code = kw_codes[k];
      end
      if (code == stt_pkg::KW_TRUE || code == stt_pkg::KW_FALSE) kind = stt_pkg::K_BOOLEAN;
      else if (code == stt_pkg::KW_IF) kind = stt_pkg::K_KEYWORD;
      else kind = stt_pkg::K_IDENT;
      add_record(kind, code, tok_start, last, 1'b0);
    endfunction

    // A byte from idle: operators and unknowns emit at once, other tokens open a mode.
    function void start_token(logic [7:0] c, logic [POS_BITS-1:0] idx);
      logic [4:0] op;
      op = stt_pkg::K_EOF;
      case (c)
        stt_pkg::CH_SPACE, stt_pkg::CH_NEWLINE, stt_pkg::CH_TAB: return;
        "+": op = stt_pkg::K_PLUS;
        "-": op = stt_pkg::K_MINUS;
        "=": op = stt_pkg::K_EQUAL;
        "*": op = stt_pkg::K_ASTERISK;
        "\\": op = stt_pkg::K_BACKSLASH;
        "^": op = stt_pkg::K_POWER;
        "!": op = stt_pkg::K_BANG;
        "(": op = stt_pkg::K_OPEN;
        ")": op = stt_pkg::K_CLOSE;
        stt_pkg::CH_SLASH: begin
          scan_state = stt_pkg::M_SLASH;
          tok_start = idx;
          return;
        end
        stt_pkg::CH_DQUOTE, stt_pkg::CH_BACKTICK, stt_pkg::CH_SQUOTE: begin
          scan_state = stt_pkg::M_STRING;
          quote = c;
          tok_start = (idx != POS_MAX) ? idx + 1'b1 : idx;
          return;
        end
        default: ;
      endcase
      if (op != stt_pkg::K_EOF) begin
        add_record(op, stt_pkg::KW_NONE, idx, idx, 1'b0);
      end else if (is_digit(c)) begin
        scan_state = stt_pkg::M_NUMBER;
        tok_start = idx;
      end else if (is_alpha(c)) begin
        scan_state = stt_pkg::M_IDENT;
        tok_start = idx;
        cand = 3'b111;
        id_len = '0;
        take_ident_char(c);
      end else begin
        add_record(stt_pkg::K_UNKNOWN, stt_pkg::KW_NONE, idx, idx, 1'b0);
      end
    endfunction

    // Works out the records caused by one accepted text item.
    function void note_item(logic [7:0] c, logic end_marker);
      logic [POS_BITS-1:0] idx;
      logic [POS_BITS-1:0] prv;
      item_records = {};
      idx = pos;
      prv = (pos != '0) ? pos - 1'b1 : '0;
      if (end_marker) begin
        case (scan_state)
          stt_pkg::M_SLASH:
            add_record(stt_pkg::K_SLASH, stt_pkg::KW_NONE, tok_start, tok_start, 1'b0);
          stt_pkg::M_STRING:
            add_record(stt_pkg::K_STRING, stt_pkg::KW_NONE, tok_start, pos, 1'b1);
          stt_pkg::M_NUMBER:
            add_record(stt_pkg::K_NUMBER, stt_pkg::KW_NONE, tok_start, prv, 1'b0);
          stt_pkg::M_IDENT:  finish_ident(prv);
          default: ;
        endcase
        add_record(stt_pkg::K_EOF, stt_pkg::KW_NONE, pos, pos, 1'b0);
        scan_state = stt_pkg::M_IDLE;
        pos = '0;
        ovf = 1'b0;
      end else begin
        if (pos != POS_MAX) pos++;
        else ovf = 1'b1;
        case (scan_state)
          stt_pkg::M_SLASH: begin
            if (c == stt_pkg::CH_SLASH) begin
              scan_state = stt_pkg::M_COMMENT;
            end else begin
              add_record(stt_pkg::K_SLASH, stt_pkg::KW_NONE, tok_start, tok_start, 1'b0);
              scan_state = stt_pkg::M_IDLE;
              start_token(c, idx);
            end
          end
          stt_pkg::M_COMMENT: begin
            if (c == stt_pkg::CH_NEWLINE) scan_state = stt_pkg::M_IDLE;
          end
          stt_pkg::M_STRING: begin
            if (c == quote) begin
              add_record(stt_pkg::K_STRING, stt_pkg::KW_NONE, tok_start, idx, 1'b0);
              scan_state = stt_pkg::M_IDLE;
            end
          end
          stt_pkg::M_NUMBER: begin
            if (!is_digit(c)) begin
              add_record(stt_pkg::K_NUMBER, stt_pkg::KW_NONE, tok_start, prv, 1'b0);
              scan_state = stt_pkg::M_IDLE;
              start_token(c, idx);
            end
          end
          stt_pkg::M_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
              take_ident_char(c);
            end else begin
              finish_ident(prv);
              scan_state = stt_pkg::M_IDLE;
              start_token(c, idx);
            end
          end
          default: begin
            scan_state = stt_pkg::M_IDLE;
            start_token(c, idx);
          end
        endcase
      end
      if (item_records.size() > 0) item_records[item_records.size()-1].last_of_run = 1'b1;
      foreach (item_records[i]) expected_tokens.push_back(item_records[i]);
    endfunction

    function void compare_field(string name, longint unsigned exp, longint unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, got %0d", name, exp, act);
        mismatches++;
      end
    endfunction

    // Compares one delivered record with the oldest expected one.
    function void check_record(stt_pkg::rec_t got);
      stt_pkg::rec_t exp;
      records_checked++;
      if (expected_tokens.size() == 0) begin
        $error("token record with none expected: kind %0d start %0d end %0d",
               got.token_kind, got.start_pos, got.end_pos);
        mismatches++;
        return;
      end
      exp = expected_tokens.pop_front();
      compare_field("token_kind", exp.token_kind, got.token_kind);
      compare_field("keyword_code", exp.keyword_code, got.keyword_code);
      compare_field("start_pos", exp.start_pos, got.start_pos);
      compare_field("end_pos", exp.end_pos, got.end_pos);
      compare_field("unterminated", exp.unterminated, got.unterminated);
      compare_field("pos_overflow", exp.pos_overflow, got.pos_overflow);
      compare_field("last_of_run", exp.last_of_run, got.last_of_run);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  token_scoreboard sb;

  string ident_words[12] = '{"true", "false", "if", "tru", "truex", "fals", "falsey7",
                             "iff", "i", "f", "If", "_if"};
  string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string op_chars = "+-=*\\^!()";
  logic [7:0] quote_chars[3] = '{stt_pkg::CH_DQUOTE, stt_pkg::CH_BACKTICK, stt_pkg::CH_SQUOTE};
  string blank_chars = " \n\t";

  stt_in_if text();
  stt_out_if tokens();

  source_text_tokenizer #(.POS_BITS(POS_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .text(text),
    .tokens(tokens)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Token receiver: checks each accepted record and stalls at random.
  always @(posedge clk) begin
    stt_pkg::rec_t got;
    if (!rst && tokens.valid === 1'b1 && tokens.ready === 1'b1) begin
      got.token_kind = tokens.token_kind;
      got.keyword_code = tokens.keyword_code;
      got.start_pos = tokens.start_pos;
      got.end_pos = tokens.end_pos;
      got.unterminated = tokens.unterminated;
      got.pos_overflow = tokens.pos_overflow;
      got.last_of_run = tokens.last_of_run;
      sb.check_record(got);
    end
    tokens.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one text item, idling first for as many cycles as the draws give,
  // and waits for it to be taken.
  task automatic send_item(input logic [7:0] c, input logic end_marker);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      text.valid <= 1'b0;
      @(posedge clk);
    end
    text.valid <= 1'b1;
    text.character <= c;
    text.end_marker <= end_marker;
    do @(posedge clk); while (text.ready !== 1'b1);
    sb.note_item(c, end_marker);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // One random piece of source text: mostly well-formed tokens, some noise.
  task automatic send_random_token();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 20) begin
      if ($urandom_range(1)) begin
        send_text(ident_words[$urandom_range(11)]);
      end else begin
        n = $urandom_range(10, 1);
        for (int i = 0; i < n; i++) send_item(ident_chars[$urandom_range(i == 0 ? 52 : 62)], 1'b0);
      end
    end else if (pick < 32) begin
      n = $urandom_range(5, 1);
      repeat (n) send_item(ident_chars[$urandom_range(62, 53)], 1'b0);
    end else if (pick < 50) begin
      send_item(op_chars[$urandom_range(8)], 1'b0);
    end else if (pick < 58) begin
      n = $urandom_range(2);
      send_item(quote_chars[n], 1'b0);
      repeat ($urandom_range(6)) send_item(8'($urandom_range(255)), 1'b0);
      if ($urandom_range(9) != 0) send_item(quote_chars[n], 1'b0);
    end else if (pick < 64) begin
      send_text("//");
      repeat ($urandom_range(5)) send_item(8'($urandom_range(255)), 1'b0);
      if ($urandom_range(4) != 0) send_item(stt_pkg::CH_NEWLINE, 1'b0);
    end else if (pick < 68) begin
      send_item(stt_pkg::CH_SLASH, 1'b0);
    end else if (pick < 85) begin
      repeat ($urandom_range(3, 1)) send_item(blank_chars[$urandom_range(2)], 1'b0);
    end else if (pick < 93) begin
      send_item(8'($urandom_range(255)), 1'b0);
    end else begin
      send_item(8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic run_random_phase(input int sender_pct, input int receiver_pct);
    int start_count;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS_PER_PHASE) send_random_token();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // Stimulus and end of run.
  initial begin
    sb = new();
    items_sent = 0;
    send_idle_pct = 6;
    recv_idle_pct = 58;
    text.valid <= 1'b0;
    text.character <= '0;
    text.end_marker <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every operator, the top byte, keywords, a lone slash at end of input,
    // a zero byte, a string cut off by end of input, and a comment at end of input.
    send_text("+-=*\\^!()");
    send_item(8'hFF, 1'b0);
    send_text("if 7/");
    send_item(8'h00, 1'b1);
    send_text("false");
    send_item(8'h00, 1'b0);
    send_item(stt_pkg::CH_BACKTICK, 1'b0);
    send_text("x");
    send_item(8'hFF, 1'b1);
    send_text("true//");
    send_item(8'h00, 1'b1);

    run_random_phase(6, 58);
    run_random_phase(58, 6);
    run_random_phase(0, 0);

    text.valid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d text items and checked %0d token records across three idling phases,",
             items_sent, sb.records_checked);
    $display("after directed cases for operators, keywords and tokens cut off by end of input.");
    if (sb.mismatches == 0 && sb.expected_tokens.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
